// ===== rtl/mamf_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the multichannel converter mean filter
// no dependencies; imported by every rtl module of the block

package mamf_pkg;

  // fixed field widths of the stream payload
  localparam int CHANNEL_W   = 3;
  localparam int SAMPLE_W    = 10;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // defaults for the top level parameters
  localparam int DEF_WINDOW_LENGTH = 16;
  localparam int DEF_CHANNEL_COUNT = 5;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;     // transaction accepted: write ring, latch item, clear sum
    logic rd_en;     // read one ring entry for the sum
    logic mul_en;    // register sum times reciprocal
    logic load_out;  // move the mean into the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_hold;  // output register full and not taken this cycle
  } sts_t;

endpackage

// ===== rtl/multichannel_adc_mean_filter_top.sv =====
`timescale 1ns / 1ps
// Multichannel converter mean filter. Each input transaction carries a 10-bit
// sample and its channel number (in_tuser). The sample goes into that channel's
// ring of the last WINDOW_LENGTH samples and the result transaction returns the
// truncated mean of the ring together with the raw sample. Entries not yet
// written count as zero, so early means include them; a channel number of
// CHANNEL_COUNT or above changes nothing and returns a mean of zero. The ring
// memory has a single read port, so the sum reads one entry a cycle during the
// S_READ sweep over the window. S_ACC then adds the last entry read, S_MUL
// scales the sum and S_OUT loads the output register. in_tready is high only
// between items, so no new transaction is taken while an item is in flight. A
// finished result waits in the output register while the next item is being
// summed. A result that is still waiting when the next mean is ready holds the
// controller until it is taken. No clearing pass follows reset: a per-channel
// wrapped flag and write position mask entries not yet written.
// depends on mamf_pkg, mamf_ctrl and mamf_datapath

module multichannel_adc_mean_filter_top #(
  parameter int WINDOW_LENGTH = mamf_pkg::DEF_WINDOW_LENGTH,
  parameter int CHANNEL_COUNT = mamf_pkg::DEF_CHANNEL_COUNT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mamf_pkg::IN_TDATA_W-1:0]      in_tdata,   // sample [9:0], zero pad [15:10]
  input  logic [mamf_pkg::CHANNEL_W-1:0]       in_tuser,   // channel [2:0]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mamf_pkg::OUT_TDATA_W-1:0]     out_tdata   // average_value [9:0],
                                                           // raw_sample [19:10], pad [23:20]
);
  import mamf_pkg::*;

  localparam int POS_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

  cmd_t                cmd;
  sts_t                sts;
  logic [POS_W-1:0]    rd_idx;
  logic [SAMPLE_W-1:0] avg;
  logic [SAMPLE_W-1:0] raw;

  // sequencing
  mamf_ctrl #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .POS_W         (POS_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd),
    .rd_idx   (rd_idx)
  );

  // rings, sum and output register
  mamf_datapath #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .POS_W         (POS_W)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_channel  (in_tuser),
    .in_sample   (in_tdata[SAMPLE_W-1:0]),
    .cmd         (cmd),
    .rd_idx      (rd_idx),
    .sts         (sts),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_average (avg),
    .out_raw     (raw)
  );

  assign out_tdata = {(OUT_TDATA_W - 2 * SAMPLE_W)'(0), raw, avg};

endmodule

// ===== rtl/mamf_ctrl.sv =====
`timescale 1ns / 1ps
// controller of the mean filter: sequences write, ring sweep, scaling and output
// depends on mamf_pkg for the command and status structs

module mamf_ctrl #(
  parameter int WINDOW_LENGTH = mamf_pkg::DEF_WINDOW_LENGTH,
  parameter int POS_W         = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mamf_pkg::sts_t   sts,
  output mamf_pkg::cmd_t   cmd,
  output logic [POS_W-1:0] rd_idx
);
  import mamf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ACC,
    S_MUL,
    S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_last;

  assign cnt_last = (cnt_r == POS_W'(WINDOW_LENGTH - 1));

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_hold) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_idx = cnt_r;

  // state and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // a new transaction always starts the ring sweep at entry zero
  a_start_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (cmd.rd_en && (rd_idx == '0)))
    else $error("sweep did not follow an accepted transaction");

  // no further transaction is taken while one is in flight
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !in_ready)
    else $error("input ready right after a transaction");

  // the output register is only loaded when it is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.out_hold)
    else $error("result overwrote a waiting result");

  // scaling only follows the end of the sweep
  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_en |-> $past(state_r == S_ACC))
    else $error("scaling out of order");

endmodule

// ===== rtl/mamf_datapath.sv =====
`timescale 1ns / 1ps
// datapath of the mean filter: sample rings, write positions, sum, scaling, output register
// depends on mamf_pkg; driven by mamf_ctrl commands

module mamf_datapath #(
  parameter int WINDOW_LENGTH = mamf_pkg::DEF_WINDOW_LENGTH,
  parameter int CHANNEL_COUNT = mamf_pkg::DEF_CHANNEL_COUNT,
  parameter int POS_W         = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mamf_pkg::CHANNEL_W-1:0]      in_channel,
  input  logic [mamf_pkg::SAMPLE_W-1:0]       in_sample,
  input  mamf_pkg::cmd_t                      cmd,
  input  logic [POS_W-1:0]                    rd_idx,
  output mamf_pkg::sts_t                      sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [mamf_pkg::SAMPLE_W-1:0]       out_average,
  output logic [mamf_pkg::SAMPLE_W-1:0]       out_raw
);
  import mamf_pkg::*;

  localparam int LOG_N    = $clog2(WINDOW_LENGTH);
  localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int DEPTH    = CHANNEL_COUNT * WINDOW_LENGTH;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W    = SAMPLE_W + LOG_N;
  localparam int SHIFT    = SUM_W + LOG_N;
  localparam int PROD_W   = 2 * SUM_W + 1;
  // ceil(2^SHIFT / N): exact truncated quotient for every sum below 2^SUM_W
  localparam logic [SUM_W:0] RECIP =
    (SUM_W + 1)'(((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

  // sample rings, one row of WINDOW_LENGTH entries per channel
  logic [SAMPLE_W-1:0] mem [DEPTH];

  // per channel write position and wrapped flag
  logic [POS_W-1:0] pos_r  [CHANNEL_COUNT];
  logic             wrap_r [CHANNEL_COUNT];

  logic [CH_IDX_W-1:0] ch_idx;
  logic                in_range;
  logic [POS_W-1:0]    pos_cur, pos_next;
  logic                pos_last, wrap_next;
  logic [ADDR_W-1:0]   base_in, wr_addr;

  logic [ADDR_W-1:0]   base_r;
  logic [POS_W-1:0]    pos_lat_r;
  logic                wrap_lat_r;
  logic                in_range_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] rdata_r;
  logic                rd_q_r;
  logic                keep_r;
  logic [SUM_W-1:0]    acc_r;
  logic [PROD_W-1:0]   prod_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] avg_r;
  logic [SAMPLE_W-1:0] raw_r;

  // channel decode and write address
  assign in_range  = ({2'b00, in_channel} < (CHANNEL_W + 2)'(CHANNEL_COUNT));
  assign ch_idx    = CH_IDX_W'({1'b0, in_channel});
  assign pos_cur   = pos_r[ch_idx];
  assign pos_last  = (pos_cur == POS_W'(WINDOW_LENGTH - 1));
  assign pos_next  = pos_last ? '0 : pos_cur + 1'b1;
  assign wrap_next = wrap_r[ch_idx] | pos_last;
  assign base_in   = ADDR_W'(ch_idx * WINDOW_LENGTH);
  assign wr_addr   = base_in + ADDR_W'(pos_cur);

  // ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.start && in_range) begin
      mem[wr_addr] <= in_sample;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[base_r + ADDR_W'(rd_idx)];
    end
  end

  // write positions and wrapped flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        pos_r[c]  <= '0;
        wrap_r[c] <= 1'b0;
      end
    end else if (cmd.start && in_range) begin
      pos_r[ch_idx]  <= pos_next;
      wrap_r[ch_idx] <= wrap_next;
    end
  end

  // item latch at the start of a transaction
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      base_r     <= base_in;
      pos_lat_r  <= pos_next;
      wrap_lat_r <= wrap_next;
      in_range_r <= in_range;
      sample_r   <= in_sample;
    end
  end

  // read tag: entries never written hold no sample, so they are skipped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_q_r <= 1'b0;
      keep_r <= 1'b0;
    end else begin
      rd_q_r <= cmd.rd_en;
      keep_r <= in_range_r && (wrap_lat_r || (rd_idx < pos_lat_r));
    end
  end

  // window sum
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
    end else if (rd_q_r && keep_r) begin
      acc_r <= acc_r + SUM_W'(rdata_r);
    end
  end

  // divide by the window length as a reciprocal multiply
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(acc_r) * PROD_W'(RECIP);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      avg_r <= prod_r[SHIFT +: SAMPLE_W];
      raw_r <= sample_r;
    end
  end

  assign sts.out_hold = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_average  = avg_r;
  assign out_raw      = raw_r;

endmodule
